// ===== hw/rtl/multi_stop_color_gradient_top_defines.svh =====
// Assertion macros for the gradient block.
`ifndef MULTI_STOP_COLOR_GRADIENT_TOP_DEFINES_SVH
`define MULTI_STOP_COLOR_GRADIENT_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define MSCG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define MSCG_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define MSCG_ASSERT(lbl, prop, msg)
`define MSCG_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ===== hw/rtl/mscg_pkg.sv =====
`timescale 1ns / 1ps

package mscg_pkg;

    localparam int MAX_STOPS     = 7;
    localparam int VALUE_BITS    = 16;
    localparam int CHAN_BITS     = 8;
    localparam int NUM_CHAN      = 3;
    localparam int COLOR_BITS    = CHAN_BITS * NUM_CHAN;
    localparam int STOP_BITS     = COLOR_BITS + VALUE_BITS;
    localparam int PROD_BITS     = VALUE_BITS + CHAN_BITS;
    localparam int CNT_BITS      = 3;
    localparam int CFG_IDX_BITS  = 3;
    localparam int IN_TDATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
    localparam int OUT_BITS      = 32;
    localparam int NUM_CELLS     = CHAN_BITS;

    localparam logic [CFG_IDX_BITS-1:0] REG_STOP_COUNT = CFG_IDX_BITS'(0);
    localparam int                      REG_STOP_BASE  = 1;
    localparam logic [CHAN_BITS-1:0]    ALPHA_OPAQUE   = 8'hFF;

    typedef logic [STOP_BITS-1:0]  t_stop;
    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [CHAN_BITS-1:0]  t_chan;

    typedef struct packed {
        t_chan  c0;
        logic   neg;
        t_value rem;
        t_chan  low;
        t_chan  quo;
    } t_lane;

    typedef struct packed {
        logic                 blend;
        t_value               div;
        t_lane [NUM_CHAN-1:0] lane;
    } t_cell;

    function automatic t_value stop_pos(input t_stop s);
        return s[STOP_BITS-1:COLOR_BITS];
    endfunction

    function automatic logic [COLOR_BITS-1:0] stop_color(input t_stop s);
        return s[COLOR_BITS-1:0];
    endfunction

endpackage

// ===== hw/rtl/mscg_cell.sv =====
`timescale 1ns / 1ps

module mscg_cell
    import mscg_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_cell i_cell,
    output logic  o_valid,
    output t_cell o_cell
);

    t_cell n_cell;
    t_cell r_cell;
    logic  r_valid;

    always_comb begin
        logic [VALUE_BITS:0] trial;
        n_cell = i_cell;
        for (int k = 0; k < NUM_CHAN; k++) begin
            trial = {i_cell.lane[k].rem, i_cell.lane[k].low[CHAN_BITS-1]};
            if (trial >= {1'b0, i_cell.div}) begin
                n_cell.lane[k].rem = VALUE_BITS'(trial - {1'b0, i_cell.div});
                n_cell.lane[k].quo = {i_cell.lane[k].quo[CHAN_BITS-2:0], 1'b1};
            end else begin
                n_cell.lane[k].rem = trial[VALUE_BITS-1:0];
                n_cell.lane[k].quo = {i_cell.lane[k].quo[CHAN_BITS-2:0], 1'b0};
            end
            n_cell.lane[k].low = {i_cell.lane[k].low[CHAN_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_valid = r_valid;
    assign o_cell  = r_cell;

endmodule

// ===== hw/rtl/mscg_front.sv =====
`timescale 1ns / 1ps

module mscg_front
    import mscg_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  t_value                       i_value,
    input  logic [CNT_BITS-1:0]          i_count,
    input  t_stop [MAX_STOPS-1:0]        i_stops,
    output logic                         o_valid,
    output t_cell                        o_cell
);

    logic                  n_blend;
    t_value                n_t;
    t_value                n_d;
    logic [COLOR_BITS-1:0] n_c0;
    logic [COLOR_BITS-1:0] n_c1;

    logic                  r1_valid;
    logic                  r1_blend;
    t_value                r1_t;
    t_value                r1_d;
    logic [COLOR_BITS-1:0] r1_c0;
    logic [COLOR_BITS-1:0] r1_c1;

    t_cell                 n_cell;
    t_cell                 r_cell;
    logic                  r_valid;

    // locate the segment around the value
    always_comb begin
        logic [CNT_BITS-1:0] n;
        t_stop               s_last;
        t_stop               s0;
        t_stop               s1;
        logic                found;
        n      = (i_count > CNT_BITS'(MAX_STOPS)) ? CNT_BITS'(MAX_STOPS) : i_count;
        s_last = '0;
        s0     = '0;
        s1     = '0;
        found  = 1'b0;
        for (int i = 0; i < MAX_STOPS; i++) begin
            if (i + 1 == int'(n)) begin
                s_last = i_stops[i];
            end
        end
        for (int i = 1; i < MAX_STOPS; i++) begin
            if (!found && (i < int'(n)) &&
                ((i_value <= stop_pos(i_stops[i])) || (i + 1 == int'(n)))) begin
                s0    = i_stops[i-1];
                s1    = i_stops[i];
                found = 1'b1;
            end
        end
        n_blend = 1'b0;
        n_c0    = '0;
        n_c1    = stop_color(s1);
        n_t     = i_value - stop_pos(s0);
        n_d     = stop_pos(s1) - stop_pos(s0);
        priority if (n == '0) begin
            n_c0 = '0;
        end else if (i_value <= stop_pos(i_stops[0])) begin
            n_c0 = stop_color(i_stops[0]);
        end else if (i_value >= stop_pos(s_last)) begin
            n_c0 = stop_color(s_last);
        end else begin
            n_blend = 1'b1;
            n_c0    = stop_color(s0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r_valid  <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r_valid  <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_blend <= n_blend;
            r1_t     <= n_t;
            r1_d     <= n_d;
            r1_c0    <= n_c0;
            r1_c1    <= n_c1;
            r_cell   <= n_cell;
        end
    end

    // scale each channel step by the offset into the segment
    always_comb begin
        t_chan                a;
        t_chan                b;
        t_chan                mag;
        logic [PROD_BITS-1:0] prod;
        n_cell.blend = r1_blend;
        n_cell.div   = r1_d;
        for (int k = 0; k < NUM_CHAN; k++) begin
            a    = r1_c0[k*CHAN_BITS +: CHAN_BITS];
            b    = r1_c1[k*CHAN_BITS +: CHAN_BITS];
            mag  = (b < a) ? (a - b) : (b - a);
            prod = PROD_BITS'(r1_t) * PROD_BITS'(mag);
            n_cell.lane[k].c0  = a;
            n_cell.lane[k].neg = (b < a);
            n_cell.lane[k].rem = prod[PROD_BITS-1:CHAN_BITS];
            n_cell.lane[k].low = prod[CHAN_BITS-1:0];
            n_cell.lane[k].quo = '0;
        end
    end

    assign o_valid = r_valid;
    assign o_cell  = r_cell;

endmodule

// ===== hw/rtl/multi_stop_color_gradient_top.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Signals                       Content
// s_axis    in   tvalid tready tdata[15:0]     pixel_value
// m_axis    out  tvalid tready tdata[31:0]     rgba_word
// cfg       in   we idx[2:0] wdata[39:0]       stop_count, stop_0..stop_6
//
// One beat per cycle while m_axis is not stalled; pipeline stages: segment search,
// channel multiply, eight divider cells (one quotient bit each), output register.
// Synchronous active-low reset clears the stop registers and all valid bits.
// A stall on m_axis freezes the whole chain and drops s_axis tready.
`include "multi_stop_color_gradient_top_defines.svh"

module multi_stop_color_gradient_top
    import mscg_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    input  logic [IN_TDATA_BITS-1:0] i_s_axis_tdata,   // [15:0] pixel_value
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    output logic [OUT_BITS-1:0]      o_m_axis_tdata,   // [31:0] rgba_word
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [STOP_BITS-1:0]     i_cfg_wdata
);

    logic [CNT_BITS-1:0]   r_count;
    t_stop [MAX_STOPS-1:0] r_stops;

    logic                  w_en;
    logic                  w_valid [NUM_CELLS+1];
    t_cell                 w_cell  [NUM_CELLS+1];

    logic                  r_out_valid;
    logic [OUT_BITS-1:0]   r_out_data;
    logic [OUT_BITS-1:0]   n_out_data;
    logic [NUM_CELLS+1:0]  w_pipe_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_stops <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_STOP_COUNT) begin
                r_count <= i_cfg_wdata[CNT_BITS-1:0];
            end
            for (int k = 0; k < MAX_STOPS; k++) begin
                if (i_cfg_idx == CFG_IDX_BITS'(k + REG_STOP_BASE)) begin
                    r_stops[k] <= i_cfg_wdata;
                end
            end
        end
    end

    assign w_en            = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    mscg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_axis_tvalid),
        .i_value (i_s_axis_tdata[VALUE_BITS-1:0]),
        .i_count (r_count),
        .i_stops (r_stops),
        .o_valid (w_valid[0]),
        .o_cell  (w_cell[0])
    );

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        mscg_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[g]),
            .i_cell  (w_cell[g]),
            .o_valid (w_valid[g+1]),
            .o_cell  (w_cell[g+1])
        );
    end

    always_comb begin
        t_lane l;
        n_out_data[CHAN_BITS-1:0] = ALPHA_OPAQUE;
        for (int k = 0; k < NUM_CHAN; k++) begin
            l = w_cell[NUM_CELLS].lane[k];
            if (!w_cell[NUM_CELLS].blend) begin
                n_out_data[(k+1)*CHAN_BITS +: CHAN_BITS] = l.c0;
            end else if (l.neg) begin
                n_out_data[(k+1)*CHAN_BITS +: CHAN_BITS] =
                    l.c0 - l.quo - CHAN_BITS'(l.rem != '0);
            end else begin
                n_out_data[(k+1)*CHAN_BITS +: CHAN_BITS] = l.c0 + l.quo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_valid[NUM_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    always_comb begin
        for (int k = 0; k <= NUM_CELLS; k++) begin
            w_pipe_vld[k] = w_valid[k];
        end
        w_pipe_vld[NUM_CELLS+1] = r_out_valid;
    end

    `MSCG_ASSERT(a_stall_freezes_chain, !w_en |=> $stable(w_pipe_vld), "chain moved while stalled")
    `MSCG_ASSERT(a_div_rem_bound, (w_valid[NUM_CELLS] && w_cell[NUM_CELLS].blend) |-> ((w_cell[NUM_CELLS].lane[0].rem < w_cell[NUM_CELLS].div) && (w_cell[NUM_CELLS].lane[1].rem < w_cell[NUM_CELLS].div) && (w_cell[NUM_CELLS].lane[2].rem < w_cell[NUM_CELLS].div)), "divider remainder not below divisor")
    `MSCG_ASSERT_RST(a_reset_clears_out, !i_rst_n |=> !o_m_axis_tvalid, "output valid after reset")

endmodule
